[design/psadpcm_pkg.sv]
// Shared types, constants and filter coefficient tables for the ADPCM block decoder.
`default_nettype none

package psadpcm_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned FILTER_W = 3;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 8;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned ROUND_SH = 6;
  localparam int unsigned PRED_W   = PROD_W - ROUND_SH;
  localparam int unsigned SUM_W    = PRED_W + 1;

  localparam logic [POS_W-1:0]    POS_HEADER   = 4'd0;
  localparam logic [POS_W-1:0]    POS_FLAGS    = 4'd1;
  localparam logic [POS_W-1:0]    POS_LAST     = 4'd15;
  localparam logic [FILTER_W-1:0] FILTER_MAX   = 3'd4;
  localparam logic signed [PROD_W-1:0] PRED_ROUND = 24'sd32;
  localparam logic signed [SUM_W-1:0]  SAMPLE_MIN = -19'sd32768;
  localparam logic signed [SUM_W-1:0]  SAMPLE_MAX = 19'sd32767;

  typedef struct packed {
    logic [SHIFT_W-1:0]  shift;
    logic [FILTER_W-1:0] filter;
  } hdr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    hdr_t              hdr;
    logic              block_end;
  } data_word_t;

  // First prediction tap, applied to the most recent sample.
  function automatic logic signed [COEF_W-1:0] coef_zero(input logic [FILTER_W-1:0] f);
    logic signed [COEF_W-1:0] c;
    unique case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd122;
    endcase
    return c;
  endfunction

  // Second prediction tap, applied to the sample before that.
  function automatic logic signed [COEF_W-1:0] coef_one(input logic [FILTER_W-1:0] f);
    logic signed [COEF_W-1:0] c;
    unique case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd0;
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = -8'sd60;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/psadpcm_sample.sv]
// One-sample ADPCM datapath: nibble scale, two-tap prediction, round and clamp.
`default_nettype none

module psadpcm_sample (
  input  wire logic [psadpcm_pkg::NIB_W-1:0]           nibble,
  input  wire psadpcm_pkg::hdr_t                       hdr,
  input  wire logic signed [psadpcm_pkg::SAMPLE_W-1:0] hist_one,
  input  wire logic signed [psadpcm_pkg::SAMPLE_W-1:0] hist_two,
  output logic signed [psadpcm_pkg::SAMPLE_W-1:0]      result
);
  import psadpcm_pkg::*;

  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] shifted;
  logic signed [COEF_W-1:0]   c0;
  logic signed [COEF_W-1:0]   c1;
  logic signed [PROD_W-1:0]   prod_one;
  logic signed [PROD_W-1:0]   prod_two;
  logic signed [PROD_W-1:0]   pred;
  logic signed [PRED_W-1:0]   pred_sh;
  logic signed [SUM_W-1:0]    sum;

  always_comb begin
    // place the nibble in the top bits, then scale down by the header shift
    scaled   = {nibble, {(SAMPLE_W-NIB_W){1'b0}}};
    shifted  = scaled >>> hdr.shift;
    c0       = coef_zero(hdr.filter);
    c1       = coef_one(hdr.filter);
    prod_one = PROD_W'(hist_one) * PROD_W'(c0);
    prod_two = PROD_W'(hist_two) * PROD_W'(c1);
    pred     = prod_one + prod_two + PRED_ROUND;
    pred_sh  = pred[PROD_W-1:ROUND_SH];
    sum      = {{(SUM_W-SAMPLE_W){shifted[SAMPLE_W-1]}}, shifted} + {pred_sh[PRED_W-1], pred_sh};
    if (sum < SAMPLE_MIN) begin
      result = SAMPLE_MIN[SAMPLE_W-1:0];
    end else if (sum > SAMPLE_MAX) begin
      result = SAMPLE_MAX[SAMPLE_W-1:0];
    end else begin
      result = sum[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

[design/ps_adpcm_block_decoder_core.sv]
// Top level of the 4-bit ADPCM block decoder: byte intake, sample sequencing, output register.
`default_nettype none

// The decoder takes a stream of 16-byte ADPCM blocks, one byte per word on the
// block_byte channel, and returns one decoded 16-bit sample per word on the
// sample channel. Byte 0 of each block is a header (shift in bits 3..0, filter
// in bits 6..4, filters 5..7 act as 4); byte 1 is a flags byte and is dropped.
// Each of bytes 2..15 yields two samples, low nibble first; run_last marks the
// high-nibble sample and block_last the 28th sample of the block. Prediction
// history runs on across blocks and is cleared only by rst. Header and flags
// bytes produce no sample. A data byte stays in the byte register while both
// of its nibbles are decoded, because the high-nibble sample predicts from the
// low-nibble sample and the one-sample datapath (two small multiplies, round,
// clamp) is combinational with the history registers in its loop; the output
// gives at most one sample per cycle, and only while sample_stall is low. The
// next byte is taken in the cycle the high nibble is decoded, and a finished
// sample held in the output register by sample_stall holds back the datapath,
// since each decoded sample loads that register directly.

module ps_adpcm_block_decoder_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 byte_valid,
  output logic                                      byte_stall,
  input  wire logic [psadpcm_pkg::BYTE_W-1:0]       block_byte,
  output logic                                      sample_valid,
  input  wire logic                                 sample_stall,
  output logic signed [psadpcm_pkg::SAMPLE_W-1:0]   sample,
  output logic                                      run_last,
  output logic                                      block_last
);
  import psadpcm_pkg::*;

  // byte position in the block and header of the current block
  logic [POS_W-1:0] byte_pos;
  hdr_t             cur_hdr;

  // data byte register: holds a byte while both nibbles are decoded
  logic       word_full;
  logic       word_hi;
  data_word_t word;

  // prediction history
  logic signed [SAMPLE_W-1:0] history_one;
  logic signed [SAMPLE_W-1:0] history_two;

  logic                       byte_take;
  logic                       out_free;
  logic                       fire;
  logic [NIB_W-1:0]           nibble;
  logic signed [SAMPLE_W-1:0] decoded;
  logic [FILTER_W-1:0]        hdr_filter;

  // output register may load when empty or being emptied this cycle
  assign out_free   = !sample_valid || !sample_stall;
  assign fire       = word_full && out_free;
  // accept a byte when the register is empty or its last nibble goes out now
  assign byte_stall = word_full && !(fire && word_hi);
  assign byte_take  = byte_valid && !byte_stall;
  assign nibble     = word_hi ? word.data[BYTE_W-1:NIB_W] : word.data[NIB_W-1:0];
  assign hdr_filter = block_byte[SHIFT_W +: FILTER_W];

  psadpcm_sample u_sample (
    .nibble   (nibble),
    .hdr      (word.hdr),
    .hist_one (history_one),
    .hist_two (history_two),
    .result   (decoded)
  );

  // track position and latch the header
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos       <= POS_HEADER;
      cur_hdr.shift  <= '0;
      cur_hdr.filter <= '0;
    end else if (byte_take) begin
      byte_pos <= byte_pos + POS_W'(1);
      if (byte_pos == POS_HEADER) begin
        cur_hdr.shift  <= block_byte[SHIFT_W-1:0];
        cur_hdr.filter <= (hdr_filter > FILTER_MAX) ? FILTER_MAX : hdr_filter;
      end
    end
  end

  // load data bytes, step through low then high nibble
  always_ff @(posedge clk) begin
    if (rst) begin
      word_full <= 1'b0;
      word_hi   <= 1'b0;
    end else if (byte_take && byte_pos != POS_HEADER && byte_pos != POS_FLAGS) begin
      word_full <= 1'b1;
      word_hi   <= 1'b0;
    end else if (fire && !word_hi) begin
      word_hi <= 1'b1;
    end else if (fire && word_hi) begin
      word_full <= 1'b0;
      word_hi   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      word.data      <= block_byte;
      word.hdr       <= cur_hdr;
      word.block_end <= (byte_pos == POS_LAST);
    end
  end

  // advance history with each decoded sample
  always_ff @(posedge clk) begin
    if (rst) begin
      history_one <= '0;
      history_two <= '0;
    end else if (fire) begin
      history_one <= decoded;
      history_two <= history_one;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (out_free) begin
      sample_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample     <= decoded;
      run_last   <= word_hi;
      block_last <= word_hi && word.block_end;
    end
  end

  // block end is only ever flagged on a high-nibble sample
  a_block_last_hi: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> (!block_last || run_last))
    else $error("block_last without run_last");

  // a taken low-nibble sample is followed at once by its high-nibble partner
  a_hi_follows: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && !run_last) |=> (sample_valid && run_last))
    else $error("high nibble sample did not follow low nibble");

  // the presented sample is the newest history entry
  a_hist_match: assert property (@(posedge clk) disable iff (rst)
    fire |=> (sample_valid && sample == history_one))
    else $error("history does not match presented sample");

  // new data byte only enters when the register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (byte_take && word_full) |-> (fire && word_hi))
    else $error("data byte register overwritten");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the ADPCM block decoder: byte driver, sample checker, watchdog.
module tb_top;
  import psadpcm_pkg::*;

  localparam int BYTE_COUNT   = 1900;
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE_TICKS = 40;
  localparam int PCM_LO       = -32768;
  localparam int PCM_HI       = 32767;

  typedef enum logic [FILTER_W-1:0] {
    FILT_ZERO, FILT_ONE, FILT_TWO, FILT_THREE, FILT_FOUR
  } filter_sel_e;

  // How the data bytes of a generated block are chosen.
  typedef enum int {
    FILL_RANDOM, FILL_EXTREME, FILL_QUIET, FILL_SATURATE
  } block_fill_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       run_last;
    logic                       block_last;
  } pcm_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         byte_valid = 1'b0;
  logic                         byte_stall;
  logic [BYTE_W-1:0]            block_byte = '0;
  logic                         sample_valid;
  logic                         sample_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample;
  logic                         run_last;
  logic                         block_last;

  // Decoder state mirrored by the bench.
  logic [POS_W-1:0]             dec_pos;
  logic [SHIFT_W-1:0]           dec_shift;
  logic [FILTER_W-1:0]          dec_filter;
  logic signed [SAMPLE_W-1:0]   dec_hist1;
  logic signed [SAMPLE_W-1:0]   dec_hist2;

  logic [BYTE_W-1:0] pending_bytes[$];
  pcm_word_t         pcm_expect[$];

  int  bytes_taken;
  int  headers_taken;
  int  clamp_count;
  int  samples_checked;
  int  errors;
  int  byte_gap;
  int  stall_left;
  int  idle_cycles;
  bit  byte_quiet;
  bit  sample_quiet;

  ps_adpcm_block_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .block_byte   (block_byte),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .run_last     (run_last),
    .block_last   (block_last)
  );

  always #5 clk = ~clk;

  // Mostly short idles, a few long ones; none at all during a quiet stretch.
  function automatic int draw_idle(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Decode one nibble against the running history and advance it.
  function automatic logic signed [SAMPLE_W-1:0] decode_nibble(logic [NIB_W-1:0] nib);
    int step;
    int pred;
    int total;
    int g1;
    int g2;
    int h1;
    int h2;
    case (filter_sel_e'(dec_filter))
      FILT_ZERO:  begin g1 = 0;   g2 = 0;   end
      FILT_ONE:   begin g1 = 60;  g2 = 0;   end
      FILT_TWO:   begin g1 = 115; g2 = -52; end
      FILT_THREE: begin g1 = 98;  g2 = -55; end
      default:    begin g1 = 122; g2 = -60; end
    endcase
    step = $signed({nib, 12'h000});
    step = step >>> dec_shift;
    h1 = dec_hist1;
    h2 = dec_hist2;
    pred = h1 * g1 + h2 * g2 + 32;
    total = step + (pred >>> ROUND_SH);
    if (total < PCM_LO) begin
      total = PCM_LO;
      clamp_count++;
    end else if (total > PCM_HI) begin
      total = PCM_HI;
      clamp_count++;
    end
    dec_hist2 = dec_hist1;
    dec_hist1 = total[SAMPLE_W-1:0];
    return total[SAMPLE_W-1:0];
  endfunction

  // Track one accepted byte; data bytes queue their two samples.
  task automatic decode_block_byte(logic [BYTE_W-1:0] b);
    pcm_word_t lo_word;
    pcm_word_t hi_word;
    logic [FILTER_W-1:0] f;
    if (dec_pos == POS_HEADER) begin
      f = b[6:4];
      dec_shift  = b[3:0];
      dec_filter = (f > FILTER_MAX) ? FILTER_MAX : f;
      headers_taken++;
    end else if (dec_pos != POS_FLAGS) begin
      lo_word.pcm        = decode_nibble(b[3:0]);
      lo_word.run_last   = 1'b0;
      lo_word.block_last = 1'b0;
      hi_word.pcm        = decode_nibble(b[7:4]);
      hi_word.run_last   = 1'b1;
      hi_word.block_last = (dec_pos == POS_LAST);
      pcm_expect.push_back(lo_word);
      pcm_expect.push_back(hi_word);
    end
    dec_pos = dec_pos + POS_W'(1);
  endtask

  // Byte driver: present the next queued word, hold it while stalled.
  always @(posedge clk) begin : drive_bytes
    logic [BYTE_W-1:0] next_byte;
    logic              next_valid;
    if (rst) begin
      byte_valid <= 1'b0;
      block_byte <= '0;
      byte_gap   <= 0;
      dec_pos    = '0;
      dec_shift  = '0;
      dec_filter = '0;
      dec_hist1  = '0;
      dec_hist2  = '0;
    end else begin
      next_valid = byte_valid;
      next_byte  = block_byte;
      if ($urandom_range(0, 299) == 0) byte_quiet = !byte_quiet;
      if (byte_valid && !byte_stall) begin
        decode_block_byte(block_byte);
        bytes_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (byte_gap > 0) begin
          byte_gap <= byte_gap - 1;
        end else if (pending_bytes.size() > 0) begin
          next_byte  = pending_bytes.pop_front();
          next_valid = 1'b1;
          byte_gap   <= draw_idle(byte_quiet);
        end
      end
      byte_valid <= next_valid;
      block_byte <= next_byte;
    end
  end

  // Sample checker: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin : check_samples
    pcm_word_t want;
    if (rst) begin
      sample_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) sample_quiet = !sample_quiet;
      if (sample_valid && !sample_stall) begin
        samples_checked++;
        if (pcm_expect.size() == 0) begin
          $display("%0t: unexpected sample %0d (run_last %b, block_last %b)",
                   $time, sample, run_last, block_last);
          errors++;
        end else begin
          want = pcm_expect.pop_front();
          if (sample !== want.pcm) begin
            $display("%0t: sample expected %0d, actual %0d",
                     $time, $signed(want.pcm), sample);
            errors++;
          end
          if (run_last !== want.run_last) begin
            $display("%0t: run_last expected %b, actual %b",
                     $time, want.run_last, run_last);
            errors++;
          end
          if (block_last !== want.block_last) begin
            $display("%0t: block_last expected %b, actual %b",
                     $time, want.block_last, block_last);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        sample_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else begin
        sample_stall <= 1'b0;
        stall_left   <= draw_idle(sample_quiet);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((byte_valid && !byte_stall) || (sample_valid && !sample_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d samples still due",
               $time, IDLE_LIMIT, pcm_expect.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    int          queued;
    int          pick;
    block_fill_e fill;
    logic [BYTE_W-1:0] b;

    // Directed opening: filter 1 with header bit 7 set and all-ones flags,
    // saturation at both rails, nibble extremes, then an out-of-range filter
    // with a large shift.
    pending_bytes = '{8'h90, 8'hFF,
                      8'h77, 8'h77, 8'h77, 8'h88, 8'h88, 8'h88, 8'h00,
                      8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h08, 8'h01, 8'h10,
                      8'h7D, 8'h00, 8'h7F, 8'h80, 8'hF7, 8'h08};
    queued = pending_bytes.size();
    fill   = FILL_RANDOM;

    // Random blocks: each header picks a fill style for its data bytes.
    while (queued < BYTE_COUNT) begin
      case (queued % 16)
        POS_HEADER: begin
          b = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 4'h0};
          b[3:0] = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 12))
                                                : 4'($urandom_range(13, 15));
          pick = $urandom_range(0, 99);
          if (pick < 60)      fill = FILL_RANDOM;
          else if (pick < 75) fill = FILL_EXTREME;
          else if (pick < 85) fill = FILL_QUIET;
          else                fill = FILL_SATURATE;
        end
        POS_FLAGS: b = 8'($urandom);
        default: begin
          case (fill)
            FILL_EXTREME: begin
              b[3:0] = $urandom_range(0, 1) ? 4'h7 : 4'h8;
              b[7:4] = $urandom_range(0, 1) ? 4'h7 : 4'h8;
            end
            FILL_QUIET:    b = {4'($urandom_range(0, 1)), 4'($urandom_range(0, 1))};
            FILL_SATURATE: b = ($urandom_range(0, 3) == 0) ? 8'h88 : 8'h77;
            default:       b = 8'($urandom);
          endcase
        end
      endcase
      pending_bytes.push_back(b);
      queued++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: all bytes accepted and every predicted sample seen.
    @(negedge clk);
    while (pending_bytes.size() != 0 || byte_valid || pcm_expect.size() != 0)
      @(negedge clk);
    // Let any stray extra sample show up before judging.
    repeat (SETTLE_TICKS) @(negedge clk);

    $display("covered %0d bytes over %0d block headers, all filters and shifts",
             bytes_taken, headers_taken);
    $display("checked %0d samples, %0d clamped, %0d mismatches, %0d left over",
             samples_checked, clamp_count, errors, pcm_expect.size());
    if (errors == 0 && pcm_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
